@@ sv/adwg_pkg.sv @@
// adwg_pkg: shared types and constants for the area downscale weight generator
// holds field widths, status codes and the sequencer state type
// no dependencies
package adwg_pkg;

  localparam int unsigned LenW        = 13;    // length and unit counters
  localparam int unsigned IdxW        = 12;    // src_index field
  localparam int unsigned StatW       = 2;     // status field
  localparam int unsigned MaxLen      = 4096;  // longest legal line
  localparam int unsigned MaxRatioDef = 32;    // default largest len_in / len_out

  // status codes of a result item
  localparam logic [StatW-1:0] STAT_OK       = 2'd0;
  localparam logic [StatW-1:0] STAT_BAD_CFG  = 2'd1;
  localparam logic [StatW-1:0] STAT_PAST_END = 2'd2;

  // register indexes on the config port
  localparam logic REG_LEN_IN  = 1'b0;
  localparam logic REG_LEN_OUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_EMIT
  } adwg_state_e;

endpackage

@@ sv/area_downscale_weight_gen.sv @@
// area_downscale_weight_gen: area-average downscale weight generator, top level
// one request in, a run of (src_index, weight_num) items or a single status item out, apb config port
// depends on adwg_pkg
//
// order: a weight request passes ST_START, then ST_EMIT, before its first item is
//   registered in the output register; a status item is registered from ST_START
// throughput: a request producing k weight items holds the block through ST_START
//   and ST_EMIT, one item per cycle through the shared subtractor while the output
//   is not stalled, k is at most MaxRatio + 1; a status request holds it in ST_START;
//   no new request is taken until the sequencer is back in ST_IDLE
// reset: rst_ni clears the walk state, the sequencer state and item counter and the
//   output valid, and loads len_in = 2, len_out = 1
module area_downscale_weight_gen #(
  parameter int unsigned MaxRatio = adwg_pkg::MaxRatioDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] restart, [7:1] zero
  // weight stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [11:0] src_index, [24:12] weight_num, [31:25] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  output logic        m_axis_tlast_o,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import adwg_pkg::*;

  // item counter covers MaxRatio + 1 items per request
  localparam int unsigned CntW   = $clog2(MaxRatio + 2);
  localparam int unsigned RatioW = $clog2(MaxRatio + 1);
  localparam int unsigned ProdW  = LenW + RatioW;
  localparam logic [CntW-1:0] MaxItems = CntW'(MaxRatio + 1);

  // config registers
  logic [LenW-1:0] len_in_q, len_out_q;
  // walk state
  logic [LenW-1:0] pos_q, pos_d;
  logic [LenW-1:0] used_q, used_d;
  logic [LenW-1:0] count_q, count_d;
  // sequencer
  adwg_state_e     state_q, state_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic [LenW-1:0] left_q, left_d;
  logic [LenW-1:0] w_q, w_d;
  logic [CntW-1:0] n_q, n_d;
  // output register
  logic             out_valid_q, out_valid_d;
  logic [IdxW-1:0]  out_idx_q;
  logic [LenW-1:0]  out_w_q;
  logic [StatW-1:0] out_stat_q;
  logic             out_last_q;

  logic             req_take, cfg_wr, out_free;
  logic             emit, walk_upd;
  logic [IdxW-1:0]  emit_idx;
  logic [LenW-1:0]  emit_w;
  logic [StatW-1:0] emit_stat;
  logic             emit_last;

  logic            cfg_ok;
  logic [ProdW-1:0] ratio_lim;
  logic            past_end;

  // shared subtractor: len_out - used in setup, left - w while emitting
  logic [LenW-1:0] sub_a, sub_b, sub_y;
  logic            left_zero;
  logic [CntW-1:0] n_inc;

  // ---------------------------------------------------------------- handshakes
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign req_take        = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~out_valid_q | m_axis_tready_i;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_LEN_OUT) ? 32'(len_out_q) : 32'(len_in_q);

  // ---------------------------------------------------------------- checks
  // length pair must be nonzero, ordered, within MaxLen and within the ratio
  assign ratio_lim = ProdW'(len_out_q) * ProdW'(MaxRatio);
  assign cfg_ok    = (len_out_q != '0) && (len_in_q >= len_out_q)
                   && (32'(len_in_q) <= MaxLen) && (32'(len_out_q) <= MaxLen)
                   && (ProdW'(len_in_q) <= ratio_lim);
  assign past_end  = (count_q >= len_out_q) || (used_q >= len_out_q);

  assign sub_a     = (state_q == ST_EMIT) ? left_q : len_out_q;
  assign sub_b     = (state_q == ST_EMIT) ? w_q : used_q;
  assign sub_y     = sub_a - sub_b;
  assign left_zero = (sub_y == '0);
  assign n_inc     = n_q + CntW'(1);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_take) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (!cfg_ok || past_end) begin
          // single status item, then done
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && (left_zero || n_inc == MaxItems)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    idx_d     = idx_q;
    left_d    = left_q;
    w_d       = w_q;
    n_d       = n_q;
    pos_d     = pos_q;
    used_d    = used_q;
    count_d   = count_q;
    walk_upd  = 1'b0;
    emit      = 1'b0;
    emit_idx  = '0;
    emit_w    = '0;
    emit_stat = STAT_OK;
    emit_last = 1'b1;
    case (state_q)
      ST_IDLE: begin
        // restart rewinds before the checks are made
        if (req_take && s_axis_tdata_i[0]) begin
          walk_upd = 1'b1;
          pos_d    = '0;
          used_d   = '0;
          count_d  = '0;
        end
      end
      ST_START: begin
        if (!cfg_ok) begin
          emit      = out_free;
          emit_stat = STAT_BAD_CFG;
        end else if (past_end) begin
          emit      = out_free;
          emit_stat = STAT_PAST_END;
        end else begin
          // first weight is what is left of the current source pixel
          idx_d  = pos_q;
          w_d    = sub_y;
          left_d = len_in_q;
          n_d    = '0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_idx  = idx_q[IdxW-1:0];
          emit_w    = w_q;
          emit_last = left_zero;
          n_d       = n_inc;
          if (left_zero || n_inc == MaxItems) begin
            // park the walk on the last touched pixel, or on the next one if that pixel is fully used
            walk_upd = 1'b1;
            count_d  = count_q + LenW'(1);
            if (w_q >= len_out_q) begin
              pos_d  = idx_q + LenW'(1);
              used_d = '0;
            end else begin
              pos_d  = idx_q;
              used_d = w_q;
            end
          end else begin
            idx_d  = idx_q + LenW'(1);
            left_d = sub_y;
            w_d    = (sub_y < len_out_q) ? sub_y : len_out_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = emit | (out_valid_q & ~m_axis_tready_i);

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      len_in_q    <= LenW'(2);
      len_out_q   <= LenW'(1);
      pos_q       <= '0;
      used_q      <= '0;
      count_q     <= '0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      // any register write rewinds the walk
      if (cfg_wr) begin
        if (paddr[2] == REG_LEN_OUT) begin
          len_out_q <= pwdata[LenW-1:0];
        end else begin
          len_in_q <= pwdata[LenW-1:0];
        end
        pos_q   <= '0;
        used_q  <= '0;
        count_q <= '0;
      end else if (walk_upd) begin
        pos_q   <= pos_d;
        used_q  <= used_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    left_q <= left_d;
    w_q    <= w_d;
    if (emit) begin
      out_idx_q  <= emit_idx;
      out_w_q    <= emit_w;
      out_stat_q <= emit_stat;
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_w_q, out_idx_q};
  assign m_axis_tuser_o  = out_stat_q;
  assign m_axis_tlast_o  = out_last_q;

  // ---------------------------------------------------------------- assertions
  // an ok item never carries a zero weight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == STAT_OK) |-> (m_axis_tdata_o[24:12] != '0))
    else $error("zero weight on ok item");

  // status items are single, empty and closing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != STAT_OK)
      |-> (m_axis_tlast_o && m_axis_tdata_o == '0))
    else $error("malformed status item");

  // with a legal config the walk never holds a fully used pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && cfg_ok) |-> (used_q < len_out_q))
    else $error("used units reached len_out");

  // item count per request stays within the ratio bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (n_q < MaxItems))
    else $error("item count overflow");

  // a taken request always goes to the setup cycle next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_take |=> (state_q == ST_START))
    else $error("request not started");

endmodule

@@ tb/sv/tb_area_downscale_weight_gen.sv @@
// tb_area_downscale_weight_gen: self-checking bench for the area downscale weight generator
// predicts every weight run in-bench and checks the weight stream item by item
// depends on adwg_pkg and area_downscale_weight_gen
module tb_area_downscale_weight_gen;
  import adwg_pkg::*;

  localparam int unsigned StallLimit = 3000;  // cycles with no accepted item
  localparam int unsigned HoldCycles = 400;   // long receiver hold-off
  localparam int unsigned ItemTarget = 380;   // requests to send overall

  // one weight item as it appears on the master side
  typedef struct packed {
    logic [IdxW-1:0]  src_index;
    logic [LenW-1:0]  weight_num;
    logic [StatW-1:0] status;
    logic             last;
  } weight_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request side
  logic        req_valid = 1'b0;
  logic [7:0]  req_data  = '0;
  logic        s_axis_tready_o;
  // weight side
  logic        m_axis_tvalid_o;
  logic        wt_ready  = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  // config port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // in-bench copy of the configuration and of the walk through the line
  logic [LenW-1:0] len_in_q  = 13'd2;
  logic [LenW-1:0] len_out_q = 13'd1;
  logic [LenW-1:0] walk_src_pos;
  logic [LenW-1:0] walk_used;
  logic [LenW-1:0] walk_out_count;

  weight_item_t pending_weights[$];  // predicted weight items not yet seen
  int unsigned  mismatches    = 0;
  int unsigned  sent_requests = 0;

  // idle control shared by the stimulus and the receiver
  bit          send_idle_on     = 1'b1;
  bit          recv_idle_on     = 1'b1;
  bit          hold_off_request = 1'b0;
  int unsigned hold_left        = 0;
  int unsigned stall_left       = 0;

  area_downscale_weight_gen u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (req_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (wt_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // weight run predictor
  // ---------------------------------------------------------------------------

  function automatic void rewind_walk();
    walk_src_pos   = '0;
    walk_used      = '0;
    walk_out_count = '0;
  endfunction

  function automatic void push_weight(input int unsigned idx, input int unsigned w,
                                      input logic [StatW-1:0] st, input logic last);
    weight_item_t item;
    item.src_index  = idx[IdxW-1:0];
    item.weight_num = w[LenW-1:0];
    item.status     = st;
    item.last       = last;
    pending_weights.insert(pending_weights.size(), item);
  endfunction

  // works out the weight run of one request and advances the walk
  function automatic void predict_weight_run(input logic restart);
    int unsigned li, lo, idx, w, left, n;
    bit cfg_ok;
    if (restart) rewind_walk();
    li = len_in_q;
    lo = len_out_q;
    cfg_ok = lo != 0 && li >= lo && li <= MaxLen && lo <= MaxLen && li <= MaxRatioDef * lo;
    if (!cfg_ok) begin
      // bad lengths or ratio: one status item, walk untouched
      push_weight(0, 0, STAT_BAD_CFG, 1'b1);
      return;
    end
    if (walk_out_count >= lo || walk_used >= lo) begin
      push_weight(0, 0, STAT_PAST_END, 1'b1);
      return;
    end
    // first item takes what is left of the current source pixel
    idx  = walk_src_pos;
    w    = lo - walk_used;
    left = li - w;
    push_weight(idx, w, STAT_OK, left == 0);
    n = 1;
    // then whole source pixels, the final one possibly partial
    while (left > 0 && n < MaxRatioDef + 1) begin
      idx++;
      w = (left < lo) ? left : lo;
      left -= w;
      push_weight(idx, w, STAT_OK, left == 0);
      n++;
    end
    if (w >= lo) begin
      walk_src_pos = LenW'(idx + 1);
      walk_used    = '0;
    end else begin
      walk_src_pos = LenW'(idx);
      walk_used    = LenW'(w);
    end
    walk_out_count = walk_out_count + 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // weight stream checker and receiver
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    weight_item_t want;
    if (rst_ni && m_axis_tvalid_o && wt_ready) begin
      if (pending_weights.size() == 0) begin
        $display("%0t: unexpected weight item, expected none, actual idx %0d w %0d st %0d",
                 $time, m_axis_tdata_o[11:0], m_axis_tdata_o[24:12], m_axis_tuser_o);
        mismatches++;
      end else begin
        want = pending_weights.pop_front();
        check_field("src_index", want.src_index, m_axis_tdata_o[11:0]);
        check_field("weight_num", want.weight_num, m_axis_tdata_o[24:12]);
        check_field("status", want.status, m_axis_tuser_o);
        check_field("last", want.last, m_axis_tlast_o);
      end
    end
  end

  // receiver: short random stalls, now and then a long one, and the hold-off on request
  always @(posedge clk_i) begin
    if (hold_off_request) begin
      hold_left        = HoldCycles;
      hold_off_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      wt_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      wt_ready <= 1'b0;
    end else if (recv_idle_on && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      wt_ready <= 1'b0;
    end else begin
      wt_ready <= 1'b1;
    end
  end

  // watchdog: ends the run once nothing has been accepted for too long
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((req_valid && s_axis_tready_o) || (m_axis_tvalid_o && wt_ready) || psel)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no item accepted for %0d cycles", $time, StallLimit);
    $display("tb_area_downscale_weight_gen failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // sends one request item and records the weight run it should produce
  task automatic send_request(input logic restart);
    int unsigned gap;
    int unsigned r;
    req_valid <= 1'b1;
    req_data  <= {7'b0, restart};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    predict_weight_run(restart);
    sent_requests++;
    gap = 0;
    if (send_idle_on) begin
      r = $urandom_range(0, 99);
      if (r >= 90)      gap = $urandom_range(5, 30);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    // only drop valid when a gap follows, so it never toggles within one step
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // lowers valid, waits out every predicted item and lets the block settle
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // config write: setup cycle, then access cycle; any write rewinds the walk
  task automatic write_length(input logic reg_idx, input logic [LenW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {19'($urandom), value};  // upper bits are don't-care
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_LEN_IN) len_in_q = value;
    else len_out_q = value;
    rewind_walk();
    // idle between transfers, with psel low
    @(posedge clk_i);
  endtask

  // the block is drained first, so nothing is in flight while lengths change
  task automatic set_lengths(input logic [LenW-1:0] li, input logic [LenW-1:0] lo);
    wait_idle();
    write_length(REG_LEN_IN, li);
    write_length(REG_LEN_OUT, lo);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset lengths 2 to 1: one two-item run, then past the end, then a restart
  task automatic test_reset_lengths();
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    wait_idle();
  endtask

  // every way the configuration can be invalid, each followed by a request
  task automatic test_bad_lengths();
    set_lengths(13'd5, 13'd0);      // no destination pixels
    send_request(1'b0);
    set_lengths(13'd3, 13'd5);      // upscale
    send_request(1'b1);
    set_lengths(13'd4097, 13'd4096); // line too long
    send_request(1'b0);
    set_lengths(13'd8191, 13'd8191); // both too long
    send_request(1'b0);
    set_lengths(13'd33, 13'd1);     // ratio just over the limit
    send_request(1'b0);
    set_lengths(13'd0, 13'd0);
    send_request(1'b1);
    wait_idle();
  endtask

  // extremes of the lengths and of the output fields
  task automatic test_extremes();
    set_lengths(13'd4096, 13'd4096); // full weight, top bit of weight_num
    send_request(1'b0);
    send_request(1'b0);
    wait_idle();
    set_lengths(13'd4096, 13'd128);  // longest line at the ratio limit
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    wait_idle();
    set_lengths(13'd1, 13'd1);       // shortest line
    send_request(1'b0);
    send_request(1'b0);
    wait_idle();
    set_lengths(13'd32, 13'd1);      // ratio exactly at the limit
    send_request(1'b0);
    send_request(1'b0);
    wait_idle();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    set_lengths(13'd96, 13'd9);
    send_idle_on     = 1'b0;
    hold_off_request = 1'b1;
    for (int i = 0; i < 24; i++) send_request(i == 12);
    send_idle_on = 1'b1;
    wait_idle();
  endtask

  // walk a full 4096-pixel line so src_index reaches its top, then past the end
  task automatic test_long_walk();
    set_lengths(13'd4096, 13'd128);
    for (int i = 0; i < 130; i++) send_request(1'b0);
    wait_idle();
  endtask

  // random lengths, mostly valid, with whole walks of short lines plus the odd restart
  task automatic test_random_walks();
    int unsigned r, li, lo, n;
    while (sent_requests < ItemTarget) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        lo = $urandom_range(1, 12);
        li = lo + $urandom_range(0, (31 * lo < 60) ? 31 * lo : 60);
      end else if (r < 85) begin
        lo = $urandom_range(13, 600);
        li = $urandom_range(lo, (32 * lo < MaxLen) ? 32 * lo : MaxLen);
      end else if (r < 93) begin
        // right on or just past the ratio limit
        lo = $urandom_range(1, 128);
        li = MaxRatioDef * lo + $urandom_range(0, 1);
      end else begin
        lo = $urandom_range(0, 8191);
        li = $urandom_range(0, 8191);
      end
      set_lengths(LenW'(li), LenW'(lo));
      send_idle_on = $urandom_range(0, 3) != 0;
      recv_idle_on = $urandom_range(0, 3) != 0;
      n = (lo < 14) ? lo + $urandom_range(0, 2) : $urandom_range(3, 14);
      for (int i = 0; i < n; i++) send_request($urandom_range(0, 9) == 0);
      wait_idle();
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  initial begin
    rewind_walk();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_lengths();
    test_bad_lengths();
    test_extremes();
    test_backpressure();
    test_long_walk();
    test_random_walks();

    // wait_idle above has drained everything; the extra wait below catches stray items
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_weights.size() == 0) begin
      $display("tb_area_downscale_weight_gen passed");
    end else begin
      $display("tb_area_downscale_weight_gen failed");
    end
    $finish;
  end

endmodule
